// ===== rtl/fli_flc_frame_decoder_defines.svh =====
// assertion helpers for the frame decoder
`ifndef FLI_FLC_FRAME_DECODER_DEFINES_SVH
`define FLI_FLC_FRAME_DECODER_DEFINES_SVH

// checked only outside reset
`define FLIFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define FLIFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/flifd_pkg.sv =====
package flifd_pkg;

   // default limits
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // reset values of the registers
   localparam logic [10:0] WIDTH_RST  = 11'd320;
   localparam logic [10:0] HEIGHT_RST = 11'd200;

   // frame types
   localparam logic [15:0] FT_FRAME  = 16'hF1FA;
   localparam logic [15:0] FT_PREFIX = 16'hF100;
   localparam logic [15:0] FT_FILLER = 16'h00A1;

   // chunk types
   localparam logic [15:0] CT_PAL8   = 16'd4;
   localparam logic [15:0] CT_DELTAW = 16'd7;
   localparam logic [15:0] CT_PAL6   = 16'd11;
   localparam logic [15:0] CT_DELTAL = 16'd12;
   localparam logic [15:0] CT_BLACK  = 16'd13;
   localparam logic [15:0] CT_RUN    = 16'd15;
   localparam logic [15:0] CT_COPY   = 16'd16;

   // result kinds
   localparam logic [2:0] K_BYTE_WR  = 3'd0;
   localparam logic [2:0] K_BYTE_FILL = 3'd1;
   localparam logic [2:0] K_WORD_FILL = 3'd2;
   localparam logic [2:0] K_PAL_WR   = 3'd3;
   localparam logic [2:0] K_DONE     = 3'd4;
   localparam logic [2:0] K_SKIPPED  = 3'd5;
   localparam logic [2:0] K_BAD      = 3'd6;
   localparam logic [2:0] K_UNKNOWN  = 3'd7;

   // saturation limits
   localparam logic [19:0] ADDR_MAX  = 20'hFFFFF;
   localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;
   localparam logic [16:0] ROW_MAX   = 17'h1FFFF;
   localparam logic [15:0] COL_MAX   = 16'hFFFF;
   localparam logic [9:0]  POFF_MAX  = 10'd1023;
   localparam logic [9:0]  DROW_MAX  = 10'd1023;

   typedef enum logic [25:0] {
      PH_FRAME_HDR  = 26'h0000001,
      PH_SKIP_FRAME = 26'h0000002,
      PH_CHUNK_HDR  = 26'h0000004,
      PH_FRAME_REST = 26'h0000008,
      PH_DONE       = 26'h0000010,
      PH_PAL_COUNT  = 26'h0000020,
      PH_PAL_SKIP   = 26'h0000040,
      PH_PAL_LEN    = 26'h0000080,
      PH_PAL_R      = 26'h0000100,
      PH_PAL_G      = 26'h0000200,
      PH_PAL_B      = 26'h0000400,
      PH_DL_LINES   = 26'h0000800,
      PH_DL_WORD    = 26'h0001000,
      PH_DL_SKIP    = 26'h0002000,
      PH_DL_SIZE    = 26'h0004000,
      PH_DL_FILLW   = 26'h0008000,
      PH_LC_Y       = 26'h0010000,
      PH_LC_LINES   = 26'h0020000,
      PH_LC_PKT     = 26'h0040000,
      PH_LC_SKIP    = 26'h0080000,
      PH_LC_SIZE    = 26'h0100000,
      PH_BR_PKT     = 26'h0200000,
      PH_BR_SIZE    = 26'h0400000,
      PH_RUN_COPY   = 26'h0800000,
      PH_RUN_FILL   = 26'h1000000,
      PH_CP_BYTE    = 26'h2000000
   } phase_type;

   typedef struct packed {
      logic       rows_d;
      logic [9:0] rfrom;
      logic [9:0] rto;
      logic       pal_d;
      logic [7:0] pfrom;
      logic [7:0] pto;
   } dirty_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] shift;
      logic [3:0]  bpos;
      logic [31:0] fleft;
      logic [31:0] cleft;
      logic [15:0] chunks;
      logic [4:0]  ckind;
      logic [15:0] col;
      logic [16:0] row;
      logic [15:0] lines;
      logic [15:0] pkts;
      logic [8:0]  run;
      logic [9:0]  poff;
      logic [15:0] rgb;
      logic        stopped;
      dirty_type   d;
   } st_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [19:0] address;
      logic [20:0] count;
      logic [7:0]  value_a;
      logic [7:0]  value_b;
      logic [7:0]  value_c;
      logic        rows_dirty;
      logic [9:0]  row_from;
      logic [9:0]  row_to;
      logic        pal_dirty;
      logic [7:0]  pal_from;
      logic [7:0]  pal_to;
   } rsp_type;

   // result item with the range fields cleared
   function automatic rsp_type make_rsp(logic [2:0] kind, logic [19:0] addr,
                                        logic [20:0] cnt, logic [7:0] a,
                                        logic [7:0] b, logic [7:0] c);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.address = addr;
      r.count = cnt;
      r.value_a = a;
      r.value_b = b;
      r.value_c = c;
      return r;
   endfunction

endpackage

// ===== rtl/fli_flc_frame_decoder.sv =====
// Frame stream decoder: takes one byte per item and returns frame-buffer commands, palette
// writes and frame status items. A byte is taken into an input register and decoded from there,
// so the block sustains one byte per cycle unless stalled; the only throughput limit is the
// four-entry result queue: a byte that ends a frame together with a write yields two result
// items, and the input stalls while the queue holds more than two items. The user must write
// registers over the csr_ port only while no bytes are in flight; the block does not enforce this.
`include "fli_flc_frame_decoder_defines.svh"

module fli_flc_frame_decoder
   import flifd_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [19:0] rsp_address,
   output logic [20:0] rsp_count,
   output logic [7:0]  rsp_value_a,
   output logic [7:0]  rsp_value_b,
   output logic [7:0]  rsp_value_c,
   output logic        rsp_rows_dirty,
   output logic [9:0]  rsp_row_from,
   output logic [9:0]  rsp_row_to,
   output logic        rsp_pal_dirty,
   output logic [7:0]  rsp_pal_from,
   output logic [7:0]  rsp_pal_to,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // helpers on the parser state
   function automatic st_type set_phase(st_type s, phase_type p);
      st_type t;
      t = s;
      t.phase = p;
      t.bpos = '0;
      t.shift = '0;
      return t;
   endfunction

   function automatic st_type row_add(st_type s, logic [16:0] x);
      st_type t;
      logic [17:0] sum;
      t = s;
      sum = {1'b0, s.row} + {1'b0, x};
      t.row = (sum > {1'b0, ROW_MAX}) ? ROW_MAX : sum[16:0];
      return t;
   endfunction

   function automatic st_type col_add(st_type s, logic [9:0] x);
      st_type t;
      logic [16:0] sum;
      t = s;
      sum = {1'b0, s.col} + {7'b0, x};
      t.col = (sum > {1'b0, COL_MAX}) ? COL_MAX : sum[15:0];
      return t;
   endfunction

   function automatic st_type line_end(st_type s);
      st_type t;
      t = row_add(s, 17'd1);
      if (t.lines != '0) t.lines = t.lines - 16'd1;
      if (t.lines == '0) begin
         t = set_phase(t, PH_DONE);
      end else begin
         t.col = '0;
         if (t.ckind == CT_DELTAW[4:0]) t = set_phase(t, PH_DL_WORD);
         else if (t.ckind == CT_DELTAL[4:0]) t = set_phase(t, PH_LC_PKT);
         else t = set_phase(t, PH_BR_PKT);
      end
      return t;
   endfunction

   function automatic st_type pkt_end(st_type s);
      st_type t;
      t = s;
      if (t.pkts != '0) t.pkts = t.pkts - 16'd1;
      if (t.pkts == '0) begin
         t = line_end(t);
      end else if (t.ckind == CT_DELTAW[4:0]) begin
         t = set_phase(t, PH_DL_SKIP);
      end else if (t.ckind == CT_DELTAL[4:0]) begin
         t = set_phase(t, PH_LC_SKIP);
      end else begin
         t = set_phase(t, PH_BR_SIZE);
      end
      return t;
   endfunction

   function automatic st_type end_chunk(st_type s);
      return set_phase(s, (s.chunks != '0) ? PH_CHUNK_HDR : PH_FRAME_REST);
   endfunction

   // first byte of a word is held, second completes it
   function automatic st_type take_word(st_type s, logic [7:0] b);
      st_type t;
      t = s;
      if (s.bpos == '0) begin
         t.shift = {8'h00, b};
         t.bpos = 4'd1;
      end else begin
         t.shift = '0;
         t.bpos = '0;
      end
      return t;
   endfunction

   function automatic dirty_type mark_rows(dirty_type d, logic [17:0] lo, logic [17:0] hi);
      dirty_type t;
      logic [9:0] l;
      logic [9:0] h;
      t = d;
      l = (lo > 18'(DROW_MAX)) ? DROW_MAX : lo[9:0];
      h = (hi > 18'(DROW_MAX)) ? DROW_MAX : hi[9:0];
      if (!d.rows_d) begin
         t.rows_d = 1'b1;
         t.rfrom = l;
         t.rto = h;
      end else begin
         if (l < d.rfrom) t.rfrom = l;
         if (h > d.rto) t.rto = h;
      end
      return t;
   endfunction

   function automatic dirty_type mark_pal(dirty_type d, logic [7:0] lo, logic [9:0] hi);
      dirty_type t;
      logic [7:0] h;
      t = d;
      h = (hi > 10'd255) ? 8'hFF : hi[7:0];
      if (!d.pal_d) begin
         t.pal_d = 1'b1;
         t.pfrom = lo;
         t.pto = h;
      end else begin
         if (lo < d.pfrom) t.pfrom = lo;
         if (h > d.pto) t.pto = h;
      end
      return t;
   endfunction

   // configuration registers
   logic [10:0] width_ff, height_ff;
   logic [10:0] w_eff, h_eff, w_m1;
   logic [21:0] wh_ff;
   logic        cfg_wr;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? {21'b0, height_ff} : {21'b0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_WIDTH) width_ff <= csr_pwdata[10:0];
         else height_ff <= csr_pwdata[10:0];
      end
   end

   // clamped sizes and the black fill length
   assign w_eff = (32'(width_ff) < MAX_WIDTH) ? width_ff : 11'(MAX_WIDTH);
   assign h_eff = (32'(height_ff) < MAX_HEIGHT) ? height_ff : 11'(MAX_HEIGHT);
   assign w_m1 = (w_eff != '0) ? (w_eff - 11'd1) : '0;

   always_ff @(posedge clock) begin
      wh_ff <= {11'b0, w_eff} * {11'b0, h_eff};
   end

   // input register and result queue control
   logic       in_v_ff, in_v_in;
   logic [7:0] in_b_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff, wr_ff;
   logic       proc, accept, pop;
   logic [1:0] push_n;
   rsp_type    q_ff [4];

   assign proc = in_v_ff && (cnt_ff <= 3'd2);
   assign req_stall = in_v_ff && !proc;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign pop = rsp_valid && !rsp_stall;
   assign in_v_in = accept ? 1'b1 : (proc ? 1'b0 : in_v_ff);

   always_ff @(posedge clock) begin
      if (accept) in_b_ff <= req_byte_in;
   end

   // pixel address of the current row and column
   st_type      st_ff, st_in;
   logic [27:0] row_prod;
   logic [28:0] pix_sum;
   logic [19:0] pix;
   logic [15:0] col_sel;

   assign col_sel = (st_ff.phase == PH_DL_WORD) ? {5'b0, w_m1} : st_ff.col;
   assign row_prod = st_ff.row * w_eff;
   assign pix_sum = {1'b0, row_prod} + {13'b0, col_sel};
   assign pix = (pix_sum > 29'(ADDR_MAX)) ? ADDR_MAX : pix_sum[19:0];

   // decode of one byte
   rsp_type     body_r, done_r, res0, res1;
   logic        body_e, done_e;

   always_comb begin
      st_type      s;
      logic [7:0]  b;
      logic        got;
      logic [15:0] v;
      logic [15:0] ftype;
      logic [31:0] body_len;
      logic [8:0]  sv;
      logic [8:0]  sn;
      logic [10:0] psum;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  bl;
      logic [20:0] wh_cnt;

      s = st_ff;
      b = in_b_ff;
      got = (st_ff.bpos != '0);
      v = {b, st_ff.shift[7:0]};
      ftype = '0;
      body_len = '0;
      sv = {b[7], b};
      sn = '0;
      psum = '0;
      r = '0;
      g = '0;
      bl = '0;
      wh_cnt = (wh_ff > 22'(COUNT_MAX)) ? COUNT_MAX : wh_ff[20:0];
      body_r = '0;
      done_r = '0;
      body_e = 1'b0;
      done_e = 1'b0;

      if (!st_ff.stopped) begin
         if (st_ff.phase == PH_FRAME_HDR) begin
            // frame header: size, type, chunk count, padding
            if (st_ff.bpos < 4'd4) begin
               if (st_ff.bpos == '0) s.fleft = {24'b0, b};
               else s.fleft[8*st_ff.bpos[1:0] +: 8] = b;
            end else if (st_ff.bpos == 4'd4) begin
               s.shift = {8'h00, b};
            end else if (st_ff.bpos == 4'd5) begin
               s.shift[15:8] = b;
            end else if (st_ff.bpos == 4'd6) begin
               s.chunks = {8'h00, b};
            end else if (st_ff.bpos == 4'd7) begin
               s.chunks[15:8] = b;
            end
            if (st_ff.bpos < 4'd15) begin
               s.bpos = st_ff.bpos + 4'd1;
            end else begin
               ftype = s.shift;
               body_len = (s.fleft > 32'd16) ? (s.fleft - 32'd16) : '0;
               s.fleft = body_len;
               if (ftype == FT_PREFIX || ftype == FT_FILLER) begin
                  body_r = make_rsp(K_SKIPPED, {4'b0, ftype}, '0, '0, '0, '0);
                  body_e = 1'b1;
                  s = set_phase(s, (body_len != '0) ? PH_SKIP_FRAME : PH_FRAME_HDR);
               end else if (ftype != FT_FRAME) begin
                  body_r = make_rsp(K_BAD, {4'b0, ftype}, '0, '0, '0, '0);
                  body_e = 1'b1;
                  s.stopped = 1'b1;
               end else if (body_len == '0) begin
                  done_e = 1'b1;
                  s = set_phase(s, PH_FRAME_HDR);
               end else begin
                  s = set_phase(s, (s.chunks != '0) ? PH_CHUNK_HDR : PH_FRAME_REST);
               end
            end
         end else if (st_ff.phase == PH_SKIP_FRAME) begin
            // body of a skipped frame
            if (s.fleft != '0) s.fleft = s.fleft - 32'd1;
            if (s.fleft == '0) s = set_phase(s, PH_FRAME_HDR);
         end else begin
            if (s.fleft != '0) s.fleft = s.fleft - 32'd1;
            if (st_ff.phase == PH_CHUNK_HDR) begin
               // chunk header: size then type
               if (st_ff.bpos < 4'd4) begin
                  if (st_ff.bpos == '0) s.cleft = {24'b0, b};
                  else s.cleft[8*st_ff.bpos[1:0] +: 8] = b;
               end else if (st_ff.bpos == 4'd4) begin
                  s.shift = {8'h00, b};
               end else begin
                  s.shift[15:8] = b;
               end
               if (st_ff.bpos < 4'd5) begin
                  s.bpos = st_ff.bpos + 4'd1;
               end else begin
                  ftype = s.shift;
                  s.cleft = (s.cleft > 32'd6) ? (s.cleft - 32'd6) : '0;
                  if (s.chunks != '0) s.chunks = s.chunks - 16'd1;
                  s.ckind = ftype[4:0];
                  s.row = '0;
                  s.col = '0;
                  if (ftype == CT_PAL8 || ftype == CT_PAL6) begin
                     s.poff = '0;
                     s = set_phase(s, PH_PAL_COUNT);
                  end else if (ftype == CT_DELTAW) begin
                     s = set_phase(s, PH_DL_LINES);
                  end else if (ftype == CT_DELTAL) begin
                     s = set_phase(s, PH_LC_Y);
                  end else if (ftype == CT_BLACK) begin
                     if (wh_ff != '0) begin
                        body_r = make_rsp(K_BYTE_FILL, '0, wh_cnt, '0, '0, '0);
                        body_e = 1'b1;
                     end
                     if (h_eff != '0) s.d = mark_rows(s.d, '0, {7'b0, h_eff} - 18'd1);
                     s = set_phase(s, PH_DONE);
                  end else if (ftype == CT_RUN) begin
                     s.lines = {5'b0, h_eff};
                     if (h_eff != '0) s.d = mark_rows(s.d, '0, {7'b0, h_eff} - 18'd1);
                     s = set_phase(s, (h_eff != '0) ? PH_BR_PKT : PH_DONE);
                  end else if (ftype == CT_COPY) begin
                     s.lines = {5'b0, h_eff};
                     if (h_eff != '0) s.d = mark_rows(s.d, '0, {7'b0, h_eff} - 18'd1);
                     s = set_phase(s, (w_eff != '0 && h_eff != '0) ? PH_CP_BYTE : PH_DONE);
                  end else begin
                     s.ckind = '0;
                     body_r = make_rsp(K_UNKNOWN, {4'b0, ftype}, '0, '0, '0, '0);
                     body_e = 1'b1;
                     s = set_phase(s, PH_DONE);
                  end
                  if (s.cleft == '0) s = end_chunk(s);
               end
            end else if (st_ff.phase != PH_FRAME_REST) begin
               // chunk body
               if (s.cleft != '0) s.cleft = s.cleft - 32'd1;
               unique case (st_ff.phase)
                  PH_PAL_COUNT: begin
                     s = take_word(s, b);
                     if (got) begin
                        s.pkts = v;
                        s = set_phase(s, (v != '0) ? PH_PAL_SKIP : PH_DONE);
                     end
                  end
                  PH_PAL_SKIP: begin
                     psum = {1'b0, s.poff} + {3'b0, b};
                     s.poff = (psum > {1'b0, POFF_MAX}) ? POFF_MAX : psum[9:0];
                     s = set_phase(s, PH_PAL_LEN);
                  end
                  PH_PAL_LEN: begin
                     s.run = (b != '0) ? {1'b0, b} : 9'd256;
                     if (s.poff <= 10'd255) begin
                        s.d = mark_pal(s.d, s.poff[7:0], s.poff + {1'b0, s.run} - 10'd1);
                     end
                     s = set_phase(s, PH_PAL_R);
                  end
                  PH_PAL_R: begin
                     s.rgb = {8'h00, b};
                     s = set_phase(s, PH_PAL_G);
                  end
                  PH_PAL_G: begin
                     s.rgb[15:8] = b;
                     s = set_phase(s, PH_PAL_B);
                  end
                  PH_PAL_B: begin
                     r = s.rgb[7:0];
                     g = s.rgb[15:8];
                     bl = b;
                     // 8-bit palette components scale down to 6 bits
                     if (s.ckind == CT_PAL8[4:0]) begin
                        r = r >> 2;
                        g = g >> 2;
                        bl = bl >> 2;
                     end
                     if (s.poff <= 10'd255) begin
                        body_r = make_rsp(K_PAL_WR, {10'b0, s.poff}, '0, r, g, bl);
                        body_e = 1'b1;
                     end
                     if (s.poff < POFF_MAX) s.poff = s.poff + 10'd1;
                     if (s.run != '0) s.run = s.run - 9'd1;
                     if (s.run != '0) begin
                        s = set_phase(s, PH_PAL_R);
                     end else begin
                        if (s.pkts != '0) s.pkts = s.pkts - 16'd1;
                        s = set_phase(s, (s.pkts != '0) ? PH_PAL_SKIP : PH_DONE);
                     end
                  end
                  PH_DL_LINES: begin
                     s = take_word(s, b);
                     if (got) begin
                        s.lines = v;
                        s = set_phase(s, (v != '0) ? PH_DL_WORD : PH_DONE);
                     end
                  end
                  PH_DL_WORD: begin
                     s = take_word(s, b);
                     if (got) begin
                        if (v[15]) begin
                           // line skip or last-pixel write
                           if (v[14]) begin
                              s = row_add(s, 17'h10000 - {1'b0, v});
                           end else begin
                              body_r = make_rsp(K_BYTE_WR, pix, '0, v[7:0], '0, '0);
                              body_e = 1'b1;
                           end
                           s = set_phase(s, PH_DL_WORD);
                        end else begin
                           s.pkts = v;
                           s.col = '0;
                           s.d = mark_rows(s.d, {1'b0, s.row}, {1'b0, s.row});
                           if (v != '0) s = set_phase(s, PH_DL_SKIP);
                           else s = line_end(s);
                        end
                     end
                  end
                  PH_DL_SKIP: begin
                     s = col_add(s, {2'b0, b});
                     s = set_phase(s, PH_DL_SIZE);
                  end
                  PH_DL_SIZE: begin
                     if (!b[7] && b != '0) begin
                        s.run = {b, 1'b0};
                        s = set_phase(s, PH_RUN_COPY);
                     end else if (b[7]) begin
                        s.run = -sv;
                        s = set_phase(s, PH_DL_FILLW);
                     end else begin
                        s = pkt_end(s);
                     end
                  end
                  PH_DL_FILLW: begin
                     s = take_word(s, b);
                     if (got) begin
                        body_r = make_rsp(K_WORD_FILL, pix, {12'b0, s.run}, v[7:0], v[15:8], '0);
                        body_e = 1'b1;
                        s = col_add(s, {s.run, 1'b0});
                        s = pkt_end(s);
                     end
                  end
                  PH_LC_Y: begin
                     s = take_word(s, b);
                     if (got) begin
                        s.row = {1'b0, v};
                        s = set_phase(s, PH_LC_LINES);
                     end
                  end
                  PH_LC_LINES: begin
                     s = take_word(s, b);
                     if (got) begin
                        s.lines = v;
                        if (v != '0) begin
                           s.d = mark_rows(s.d, {1'b0, s.row},
                                           {1'b0, s.row} + {2'b0, v} - 18'd1);
                        end
                        s = set_phase(s, (v != '0) ? PH_LC_PKT : PH_DONE);
                     end
                  end
                  PH_LC_PKT, PH_BR_PKT: begin
                     s.pkts = {8'h00, b};
                     s.col = '0;
                     if (b != '0) begin
                        s = set_phase(s, (st_ff.phase == PH_LC_PKT) ? PH_LC_SKIP : PH_BR_SIZE);
                     end else begin
                        s = line_end(s);
                     end
                  end
                  PH_LC_SKIP: begin
                     s = col_add(s, {2'b0, b});
                     s = set_phase(s, PH_LC_SIZE);
                  end
                  PH_LC_SIZE, PH_BR_SIZE: begin
                     if (b == '0) begin
                        s = pkt_end(s);
                     end else begin
                        // byte run counts are negated relative to line delta
                        sn = (st_ff.phase == PH_BR_SIZE) ? -sv : sv;
                        if (!sn[8]) begin
                           s.run = sn;
                           s = set_phase(s, PH_RUN_COPY);
                        end else begin
                           s.run = -sn;
                           s = set_phase(s, PH_RUN_FILL);
                        end
                     end
                  end
                  PH_RUN_COPY: begin
                     body_r = make_rsp(K_BYTE_WR, pix, '0, b, '0, '0);
                     body_e = 1'b1;
                     s = col_add(s, 10'd1);
                     if (s.run != '0) s.run = s.run - 9'd1;
                     if (s.run == '0) s = pkt_end(s);
                  end
                  PH_RUN_FILL: begin
                     body_r = make_rsp(K_BYTE_FILL, pix, {12'b0, s.run}, b, '0, '0);
                     body_e = 1'b1;
                     s = col_add(s, {1'b0, s.run});
                     s = pkt_end(s);
                  end
                  PH_CP_BYTE: begin
                     body_r = make_rsp(K_BYTE_WR, pix, '0, b, '0, '0);
                     body_e = 1'b1;
                     s = col_add(s, 10'd1);
                     if (s.col >= {5'b0, w_eff}) begin
                        s.col = '0;
                        s = row_add(s, 17'd1);
                        if (s.lines != '0) s.lines = s.lines - 16'd1;
                        if (s.lines == '0) s = set_phase(s, PH_DONE);
                     end
                  end
                  default: begin
                  end
               endcase
               if (s.cleft == '0) s = end_chunk(s);
            end
            // frame end closes any open chunk
            if (s.fleft == '0) begin
               done_e = 1'b1;
               s = set_phase(s, PH_FRAME_HDR);
            end
         end

         // frame done carries the ranges and clears them
         if (done_e) begin
            done_r = make_rsp(K_DONE, '0, '0, '0, '0, '0);
            done_r.rows_dirty = s.d.rows_d;
            done_r.row_from = s.d.rows_d ? s.d.rfrom : '0;
            done_r.row_to = s.d.rows_d ? s.d.rto : '0;
            done_r.pal_dirty = s.d.pal_d;
            done_r.pal_from = s.d.pal_d ? s.d.pfrom : '0;
            done_r.pal_to = s.d.pal_d ? s.d.pto : '0;
            s.d = '0;
         end
      end
      st_in = s;
   end

   // order the results: command first, frame done after it
   assign res0 = body_e ? body_r : done_r;
   assign res1 = done_r;
   assign push_n = proc ? ({1'b0, body_e} + {1'b0, done_e}) : 2'd0;
   assign cnt_in = cnt_ff - {2'b0, pop} + {1'b0, push_n};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= set_phase('0, PH_FRAME_HDR);
         in_v_ff <= 1'b0;
         cnt_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         if (proc) st_ff <= st_in;
         in_v_ff <= in_v_in;
         cnt_ff <= cnt_in;
         if (pop) rd_ff <= rd_ff + 2'd1;
         wr_ff <= wr_ff + push_n;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) q_ff[wr_ff] <= res0;
      if (push_n == 2'd2) q_ff[wr_ff + 2'd1] <= res1;
   end

   assign rsp_kind = q_ff[rd_ff].kind;
   assign rsp_address = q_ff[rd_ff].address;
   assign rsp_count = q_ff[rd_ff].count;
   assign rsp_value_a = q_ff[rd_ff].value_a;
   assign rsp_value_b = q_ff[rd_ff].value_b;
   assign rsp_value_c = q_ff[rd_ff].value_c;
   assign rsp_rows_dirty = q_ff[rd_ff].rows_dirty;
   assign rsp_row_from = q_ff[rd_ff].row_from;
   assign rsp_row_to = q_ff[rd_ff].row_to;
   assign rsp_pal_dirty = q_ff[rd_ff].pal_dirty;
   assign rsp_pal_from = q_ff[rd_ff].pal_from;
   assign rsp_pal_to = q_ff[rd_ff].pal_to;

   // checks
   `FLIFD_ASSERT_ALWAYS(a_reset_empty, reset |=> (cnt_ff == 3'd0), "queue not empty after reset")
   `FLIFD_ASSERT(a_queue_bound, cnt_ff <= 3'd4, "result queue overflow")
   `FLIFD_ASSERT(a_stop_sticks, st_ff.stopped |=> st_ff.stopped, "stop cleared without reset")
   `FLIFD_ASSERT(a_stop_silent, st_ff.stopped |-> push_n == 2'd0, "result after bad magic")
   `FLIFD_ASSERT(a_pair_done, (push_n == 2'd2) |-> res1.kind == K_DONE,
      "second result of a byte is not frame done")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import flifd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [2:0] ADDR_WIDTH  = {2'b00, REG_WIDTH} << 2;
   localparam logic [2:0] ADDR_HEIGHT = {2'b00, REG_HEIGHT} << 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [19:0] rsp_address;
   logic [20:0] rsp_count;
   logic [7:0]  rsp_value_a, rsp_value_b, rsp_value_c;
   logic        rsp_rows_dirty, rsp_pal_dirty;
   logic [9:0]  rsp_row_from, rsp_row_to;
   logic [7:0]  rsp_pal_from, rsp_pal_to;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fli_flc_frame_decoder uut (.*);

   always #2 clock = ~clock;

   // decoder shadow state
   int unsigned width_reg = WIDTH_RST, height_reg = HEIGHT_RST;
   phase_type   ph = PH_FRAME_HDR;
   int unsigned shift_acc, byte_pos, frame_left, chunk_left, chunks_todo, chunk_code;
   int unsigned col, row, lines_todo, pkts_todo, run_len, pal_pos, rgb_acc;
   bit          halted, rows_dirty, pal_dirty;
   int unsigned row_lo, row_hi, pal_lo, pal_hi;
   int          n_made;
   rsp_type     cmd_q[$];

   logic [7:0]  byte_q[$];
   logic [7:0]  frame_body[$];
   logic [7:0]  chunk_body[$];
   bit          exact_sizes;
   int          errors, bytes_taken, cycles;
   int          gap_left, stall_left, free_left, hold_left, quiet_left;
   bit          hold_done;

   function int unsigned eff_w();
      return width_reg < MAX_WIDTH_DEF ? width_reg : MAX_WIDTH_DEF;
   endfunction

   function int unsigned eff_h();
      return height_reg < MAX_HEIGHT_DEF ? height_reg : MAX_HEIGHT_DEF;
   endfunction

   function int unsigned pixel_at(int unsigned c);
      longint unsigned a;
      a = longint'(row) * eff_w() + c;
      return a > ADDR_MAX ? ADDR_MAX : int'(a);
   endfunction

   function void set_ph(phase_type p);
      ph = p;
      byte_pos = 0;
      shift_acc = 0;
   endfunction

   function void row_add(int unsigned x);
      row = (row + x > ROW_MAX) ? ROW_MAX : row + x;
   endfunction

   function void col_add(int unsigned x);
      col = (col + x > COL_MAX) ? COL_MAX : col + x;
   endfunction

   function void mark_rows(int unsigned lo, int unsigned hi);
      if (lo > DROW_MAX) lo = DROW_MAX;
      if (hi > DROW_MAX) hi = DROW_MAX;
      if (!rows_dirty) begin
         rows_dirty = 1;
         row_lo = lo;
         row_hi = hi;
      end else begin
         if (lo < row_lo) row_lo = lo;
         if (hi > row_hi) row_hi = hi;
      end
   endfunction

   function void mark_pal(int unsigned lo, int unsigned hi);
      if (hi > 255) hi = 255;
      if (!pal_dirty) begin
         pal_dirty = 1;
         pal_lo = lo;
         pal_hi = hi;
      end else begin
         if (lo < pal_lo) pal_lo = lo;
         if (hi > pal_hi) pal_hi = hi;
      end
   endfunction

   function void push_cmd(logic [2:0] k, int unsigned addr, longint unsigned cnt,
                          int unsigned a, int unsigned b, int unsigned c, bit done);
      rsp_type r;
      if (n_made >= 2) return;
      r = '0;
      r.kind = k;
      r.address = addr[19:0];
      r.count = cnt > COUNT_MAX ? COUNT_MAX : cnt[20:0];
      r.value_a = a[7:0];
      r.value_b = b[7:0];
      r.value_c = c[7:0];
      if (done) begin
         r.rows_dirty = rows_dirty;
         r.row_from = rows_dirty ? row_lo[9:0] : 10'd0;
         r.row_to = rows_dirty ? row_hi[9:0] : 10'd0;
         r.pal_dirty = pal_dirty;
         r.pal_from = pal_dirty ? pal_lo[7:0] : 8'd0;
         r.pal_to = pal_dirty ? pal_hi[7:0] : 8'd0;
         rows_dirty = 0;
         pal_dirty = 0;
         row_lo = 0; row_hi = 0; pal_lo = 0; pal_hi = 0;
      end
      cmd_q.push_back(r);
      n_made++;
   endfunction

   function bit take_word(int unsigned b, output int unsigned v);
      v = 0;
      if (byte_pos == 0) begin
         shift_acc = b;
         byte_pos = 1;
         return 0;
      end
      v = shift_acc | (b << 8);
      byte_pos = 0;
      shift_acc = 0;
      return 1;
   endfunction

   function void end_chunk();
      set_ph(chunks_todo > 0 ? PH_CHUNK_HDR : PH_FRAME_REST);
   endfunction

   function void line_end();
      row_add(1);
      if (lines_todo > 0) lines_todo--;
      if (lines_todo == 0) begin
         set_ph(PH_DONE);
         return;
      end
      col = 0;
      set_ph(chunk_code == CT_DELTAW ? PH_DL_WORD :
             chunk_code == CT_DELTAL ? PH_LC_PKT : PH_BR_PKT);
   endfunction

   function void pkt_end();
      if (pkts_todo > 0) pkts_todo--;
      if (pkts_todo == 0) begin
         line_end();
         return;
      end
      set_ph(chunk_code == CT_DELTAW ? PH_DL_SKIP :
             chunk_code == CT_DELTAL ? PH_LC_SKIP : PH_BR_SIZE);
   endfunction

   function void frame_header_byte(int unsigned b);
      int unsigned pos, ftype, body;
      pos = byte_pos;
      if (pos < 4) frame_left = (pos == 0 ? 0 : frame_left) | (b << (8 * pos));
      else if (pos == 4) shift_acc = b;
      else if (pos == 5) shift_acc |= b << 8;
      else if (pos == 6) chunks_todo = b;
      else if (pos == 7) chunks_todo |= b << 8;
      if (pos < 15) begin
         byte_pos = pos + 1;
         return;
      end
      ftype = shift_acc & 16'hFFFF;
      body = frame_left > 16 ? frame_left - 16 : 0;
      frame_left = body;
      if (ftype == FT_PREFIX || ftype == FT_FILLER) begin
         push_cmd(K_SKIPPED, ftype, 0, 0, 0, 0, 0);
         set_ph(body != 0 ? PH_SKIP_FRAME : PH_FRAME_HDR);
      end else if (ftype != FT_FRAME) begin
         push_cmd(K_BAD, ftype, 0, 0, 0, 0, 0);
         halted = 1;
      end else if (body == 0) begin
         push_cmd(K_DONE, 0, 0, 0, 0, 0, 1);
         set_ph(PH_FRAME_HDR);
      end else begin
         set_ph(chunks_todo != 0 ? PH_CHUNK_HDR : PH_FRAME_REST);
      end
   endfunction

   function void chunk_header_byte(int unsigned b);
      int unsigned pos, ctype, w, h;
      longint unsigned area;
      pos = byte_pos;
      w = eff_w();
      h = eff_h();
      if (pos < 4) chunk_left = (pos == 0 ? 0 : chunk_left) | (b << (8 * pos));
      else if (pos == 4) shift_acc = b;
      else shift_acc |= b << 8;
      if (pos < 5) begin
         byte_pos = pos + 1;
         return;
      end
      ctype = shift_acc & 16'hFFFF;
      chunk_left = chunk_left > 6 ? chunk_left - 6 : 0;
      if (chunks_todo > 0) chunks_todo--;
      chunk_code = ctype & 5'h1F;
      row = 0;
      col = 0;
      area = longint'(w) * h;
      if (ctype == CT_PAL8 || ctype == CT_PAL6) begin
         pal_pos = 0;
         set_ph(PH_PAL_COUNT);
      end else if (ctype == CT_DELTAW) begin
         set_ph(PH_DL_LINES);
      end else if (ctype == CT_DELTAL) begin
         set_ph(PH_LC_Y);
      end else if (ctype == CT_BLACK) begin
         if (area != 0) push_cmd(K_BYTE_FILL, 0, area, 0, 0, 0, 0);
         if (h != 0) mark_rows(0, h - 1);
         set_ph(PH_DONE);
      end else if (ctype == CT_RUN) begin
         lines_todo = h;
         if (h != 0) mark_rows(0, h - 1);
         set_ph(h != 0 ? PH_BR_PKT : PH_DONE);
      end else if (ctype == CT_COPY) begin
         lines_todo = h;
         if (h != 0) mark_rows(0, h - 1);
         set_ph((w != 0 && h != 0) ? PH_CP_BYTE : PH_DONE);
      end else begin
         chunk_code = 0;
         push_cmd(K_UNKNOWN, ctype, 0, 0, 0, 0, 0);
         set_ph(PH_DONE);
      end
      if (chunk_left == 0) end_chunk();
   endfunction

   function void body_byte(int unsigned b);
      int unsigned v, w, r, g, bl;
      byte sb;
      int s;
      w = eff_w();
      sb = b[7:0];
      s = sb;
      case (ph)
         PH_PAL_COUNT: begin
            if (!take_word(b, v)) return;
            pkts_todo = v;
            set_ph(v != 0 ? PH_PAL_SKIP : PH_DONE);
         end
         PH_PAL_SKIP: begin
            pal_pos = (pal_pos + b > POFF_MAX) ? POFF_MAX : pal_pos + b;
            set_ph(PH_PAL_LEN);
         end
         PH_PAL_LEN: begin
            run_len = b != 0 ? b : 256;
            if (pal_pos <= 255) mark_pal(pal_pos, pal_pos + run_len - 1);
            set_ph(PH_PAL_R);
         end
         PH_PAL_R: begin
            rgb_acc = b;
            set_ph(PH_PAL_G);
         end
         PH_PAL_G: begin
            rgb_acc |= b << 8;
            set_ph(PH_PAL_B);
         end
         PH_PAL_B: begin
            r = rgb_acc & 8'hFF;
            g = (rgb_acc >> 8) & 8'hFF;
            bl = b;
            // 8-bit palettes are scaled down to six bits
            if (chunk_code == CT_PAL8) begin
               r >>= 2; g >>= 2; bl >>= 2;
            end
            if (pal_pos <= 255) push_cmd(K_PAL_WR, pal_pos, 0, r, g, bl, 0);
            if (pal_pos < POFF_MAX) pal_pos++;
            if (run_len > 0) run_len--;
            if (run_len > 0) begin
               set_ph(PH_PAL_R);
               return;
            end
            if (pkts_todo > 0) pkts_todo--;
            set_ph(pkts_todo != 0 ? PH_PAL_SKIP : PH_DONE);
         end
         PH_DL_LINES: begin
            if (!take_word(b, v)) return;
            lines_todo = v;
            set_ph(v != 0 ? PH_DL_WORD : PH_DONE);
         end
         PH_DL_WORD: begin
            if (!take_word(b, v)) return;
            // opcode words: row skip or last byte of the line
            if (v & 16'h8000) begin
               if (v & 16'h4000) row_add(65536 - v);
               else push_cmd(K_BYTE_WR, pixel_at(w != 0 ? w - 1 : 0), 0, v & 8'hFF, 0, 0, 0);
               set_ph(PH_DL_WORD);
               return;
            end
            pkts_todo = v;
            col = 0;
            mark_rows(row, row);
            if (v != 0) set_ph(PH_DL_SKIP);
            else line_end();
         end
         PH_DL_SKIP: begin
            col_add(b);
            set_ph(PH_DL_SIZE);
         end
         PH_DL_SIZE: begin
            if (s > 0) begin
               run_len = s * 2;
               set_ph(PH_RUN_COPY);
            end else if (s < 0) begin
               run_len = -s;
               set_ph(PH_DL_FILLW);
            end else pkt_end();
         end
         PH_DL_FILLW: begin
            if (!take_word(b, v)) return;
            push_cmd(K_WORD_FILL, pixel_at(col), run_len, v & 8'hFF, (v >> 8) & 8'hFF, 0, 0);
            col_add(2 * run_len);
            pkt_end();
         end
         PH_LC_Y: begin
            if (!take_word(b, v)) return;
            row = v;
            set_ph(PH_LC_LINES);
         end
         PH_LC_LINES: begin
            if (!take_word(b, v)) return;
            lines_todo = v;
            if (v != 0) mark_rows(row, row + v - 1);
            set_ph(v != 0 ? PH_LC_PKT : PH_DONE);
         end
         PH_LC_PKT, PH_BR_PKT: begin
            pkts_todo = b;
            col = 0;
            if (b != 0) set_ph(ph == PH_LC_PKT ? PH_LC_SKIP : PH_BR_SIZE);
            else line_end();
         end
         PH_LC_SKIP: begin
            col_add(b);
            set_ph(PH_LC_SIZE);
         end
         PH_LC_SIZE, PH_BR_SIZE: begin
            if (s == 0) begin
               pkt_end();
               return;
            end
            // byte run uses the opposite sign convention
            if (ph == PH_BR_SIZE) s = -s;
            if (s > 0) begin
               run_len = s;
               set_ph(PH_RUN_COPY);
            end else begin
               run_len = -s;
               set_ph(PH_RUN_FILL);
            end
         end
         PH_RUN_COPY: begin
            push_cmd(K_BYTE_WR, pixel_at(col), 0, b, 0, 0, 0);
            col_add(1);
            if (run_len > 0) run_len--;
            if (run_len == 0) pkt_end();
         end
         PH_RUN_FILL: begin
            push_cmd(K_BYTE_FILL, pixel_at(col), run_len, b, 0, 0, 0);
            col_add(run_len);
            pkt_end();
         end
         PH_CP_BYTE: begin
            push_cmd(K_BYTE_WR, pixel_at(col), 0, b, 0, 0, 0);
            col_add(1);
            if (col >= w) begin
               col = 0;
               row_add(1);
               if (lines_todo > 0) lines_todo--;
               if (lines_todo == 0) set_ph(PH_DONE);
            end
         end
         default: ;
      endcase
   endfunction

   // expected commands for one accepted stream byte
   function void decode_byte(logic [7:0] din);
      int unsigned b;
      b = din;
      n_made = 0;
      if (halted) return;
      if (ph == PH_FRAME_HDR) begin
         frame_header_byte(b);
      end else if (ph == PH_SKIP_FRAME) begin
         if (frame_left > 0) frame_left--;
         if (frame_left == 0) set_ph(PH_FRAME_HDR);
      end else begin
         if (frame_left > 0) frame_left--;
         if (ph == PH_CHUNK_HDR) begin
            chunk_header_byte(b);
         end else if (ph != PH_FRAME_REST) begin
            if (chunk_left > 0) chunk_left--;
            body_byte(b);
            if (chunk_left == 0) end_chunk();
         end
         if (frame_left == 0) begin
            push_cmd(K_DONE, 0, 0, 0, 0, 0, 1);
            set_ph(PH_FRAME_HDR);
         end
      end
   endfunction

   // idle lengths: mostly short, a few long, with stretches of none
   function int pick_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // stream building
   function void cb_b(int unsigned v);
      chunk_body.push_back(v[7:0]);
   endfunction

   function void cb_w(int unsigned v);
      chunk_body.push_back(v[7:0]);
      chunk_body.push_back(v[15:8]);
   endfunction

   function void close_chunk(logic [15:0] ctype);
      int unsigned sz;
      int r;
      sz = chunk_body.size() + 6;
      r = $urandom_range(0, 99);
      if (!exact_sizes) begin
         if (r < 8) sz = 6 + $urandom_range(0, chunk_body.size());
         else if (r < 11) sz = $urandom_range(0, 5);
         else if (r < 14) sz += $urandom_range(1, 8);
      end
      for (int i = 0; i < 4; i++) frame_body.push_back(sz[8*i +: 8]);
      frame_body.push_back(ctype[7:0]);
      frame_body.push_back(ctype[15:8]);
      foreach (chunk_body[i]) frame_body.push_back(chunk_body[i]);
      chunk_body.delete();
   endfunction

   function void close_frame(logic [15:0] ftype, int unsigned cnt, int unsigned sz);
      int r;
      r = $urandom_range(0, 99);
      if (!exact_sizes) begin
         if (r < 5) sz = $urandom_range(0, sz);
         else if (r < 8) cnt = $urandom_range(0, 1) ? cnt + 1 : cnt - 1;
      end
      for (int i = 0; i < 4; i++) byte_q.push_back(sz[8*i +: 8]);
      byte_q.push_back(ftype[7:0]);
      byte_q.push_back(ftype[15:8]);
      byte_q.push_back(cnt[7:0]);
      byte_q.push_back(cnt[15:8]);
      for (int i = 0; i < 8; i++) byte_q.push_back(8'($urandom_range(0, 255)));
      foreach (frame_body[i]) byte_q.push_back(frame_body[i]);
      frame_body.delete();
   endfunction

   function void gen_palette();
      int unsigned npk, len;
      npk = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 3);
      cb_w(npk);
      for (int p = 0; p < npk; p++) begin
         cb_b($urandom_range(0, 9) == 0 ? $urandom_range(100, 255) : $urandom_range(0, 8));
         len = $urandom_range(0, 32) == 0 ? 0 : $urandom_range(1, 4);
         cb_b(len);
         for (int i = 0; i < 3 * (len != 0 ? len : 256); i++) cb_b($urandom_range(0, 255));
      end
   endfunction

   function void gen_word_delta();
      int unsigned nl, np, k;
      int r;
      nl = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
      cb_w(nl);
      for (int l = 0; l < nl; l++) begin
         if ($urandom_range(0, 3) == 0) cb_w(65536 - $urandom_range(1, 3));
         if ($urandom_range(0, 4) == 0) cb_w(16'h8000 | $urandom_range(0, 255));
         np = $urandom_range(0, 2);
         cb_w(np);
         for (int p = 0; p < np; p++) begin
            cb_b($urandom_range(0, 8));
            r = $urandom_range(0, 99);
            k = $urandom_range(1, 3);
            if (r < 45) begin
               cb_b(k);
               for (int i = 0; i < 2 * k; i++) cb_b($urandom_range(0, 255));
            end else if (r < 90) begin
               cb_b(256 - k);
               cb_w($urandom_range(0, 65535));
            end else cb_b(0);
         end
      end
   endfunction

   function void gen_line_delta();
      int unsigned nl, np, k;
      int r;
      cb_w($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, eff_h() + 1));
      nl = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
      cb_w(nl);
      for (int l = 0; l < nl; l++) begin
         np = $urandom_range(0, 2);
         cb_b(np);
         for (int p = 0; p < np; p++) begin
            cb_b($urandom_range(0, 8));
            r = $urandom_range(0, 99);
            k = $urandom_range(1, 4);
            if (r < 50) begin
               cb_b(k);
               for (int i = 0; i < k; i++) cb_b($urandom_range(0, 255));
            end else if (r < 90) begin
               cb_b(256 - k);
               cb_b($urandom_range(0, 255));
            end else cb_b(0);
         end
      end
   endfunction

   function void gen_byte_run();
      int unsigned nl, np, k;
      int r;
      // tall frames get a few lines only, the chunk then ends short
      nl = eff_h() <= 6 ? eff_h() : $urandom_range(0, 3);
      for (int l = 0; l < nl; l++) begin
         np = $urandom_range(0, 3);
         cb_b(np);
         for (int p = 0; p < np; p++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(1, 4);
            if (r < 50) begin
               cb_b(256 - k);
               for (int i = 0; i < k; i++) cb_b($urandom_range(0, 255));
            end else if (r < 90) begin
               cb_b(k);
               cb_b($urandom_range(0, 255));
            end else cb_b(0);
         end
      end
   endfunction

   function void gen_copy();
      int unsigned n;
      n = eff_w() * eff_h() <= 64 ? eff_w() * eff_h() : $urandom_range(0, 40);
      for (int i = 0; i < n; i++) cb_b($urandom_range(0, 255));
   endfunction

   function void gen_chunk(int sel);
      logic [15:0] known [7];
      known = '{CT_PAL8, CT_PAL6, CT_DELTAW, CT_DELTAL, CT_BLACK, CT_RUN, CT_COPY};
      case (sel)
         0: begin gen_palette(); close_chunk(CT_PAL8); end
         1: begin gen_palette(); close_chunk(CT_PAL6); end
         2, 9: begin gen_word_delta(); close_chunk(CT_DELTAW); end
         3: begin gen_line_delta(); close_chunk(CT_DELTAL); end
         4: close_chunk(CT_BLACK);
         5: begin gen_byte_run(); close_chunk(CT_RUN); end
         6: begin gen_copy(); close_chunk(CT_COPY); end
         7: begin
            for (int i = $urandom_range(0, 6); i > 0; i--) cb_b($urandom_range(0, 255));
            close_chunk(16'($urandom_range(0, 1) ? $urandom_range(17, 65535)
                                                  : $urandom_range(0, 3)));
         end
         default: begin
            // known chunk type with a noise body
            for (int i = $urandom_range(0, 12); i > 0; i--) cb_b($urandom_range(0, 255));
            close_chunk(known[$urandom_range(0, 6)]);
         end
      endcase
   endfunction

   function void gen_frame();
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) gen_chunk($urandom_range(0, 9));
         if ($urandom_range(0, 9) == 0)
            for (int i = $urandom_range(1, 4); i > 0; i--)
               frame_body.push_back(8'($urandom_range(0, 255)));
         close_frame(FT_FRAME, n, frame_body.size() + 16);
      end else if (r < 90) begin
         for (int i = $urandom_range(0, 6); i > 0; i--)
            frame_body.push_back(8'($urandom_range(0, 255)));
         close_frame($urandom_range(0, 1) ? FT_PREFIX : FT_FILLER, 0, frame_body.size() + 16);
      end else if (r < 95) begin
         close_frame(FT_FRAME, $urandom_range(0, 2), $urandom_range(0, 16));
      end else begin
         // no chunks, body is skipped as leftover
         for (int i = $urandom_range(1, 8); i > 0; i--)
            frame_body.push_back(8'($urandom_range(0, 255)));
         close_frame(FT_FRAME, 0, frame_body.size() + 16);
      end
   endfunction

   // stream driver
   always @(posedge clock) begin
      logic       nv;
      logic [7:0] nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         nb = req_byte_in;
         if (req_valid && !req_stall) begin
            decode_byte(req_byte_in);
            bytes_taken++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) gap_left--;
            else if (byte_q.size() > 0) begin
               nb = byte_q.pop_front();
               nv = 1'b1;
               gap_left = pick_gap();
            end
         end
         req_valid <= nv;
         req_byte_in <= nb;
      end
   end

   // result stall, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && bytes_taken >= 300) begin
         hold_done = 1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         free_left = $urandom_range(0, 9) == 0 ? $urandom_range(50, 150) : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
      end
   end

   function void cmp(string nm, int unsigned e, int unsigned a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
         errors++;
      end
   endfunction

   // result monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cmd_q.size() == 0) begin
            $display("%0t: unexpected item, kind %0d address %0d", $time, rsp_kind, rsp_address);
            errors++;
         end else begin
            e = cmd_q.pop_front();
            cmp("kind", e.kind, rsp_kind);
            cmp("address", e.address, rsp_address);
            cmp("count", e.count, rsp_count);
            cmp("value_a", e.value_a, rsp_value_a);
            cmp("value_b", e.value_b, rsp_value_b);
            cmp("value_c", e.value_c, rsp_value_c);
            cmp("rows_dirty", e.rows_dirty, rsp_rows_dirty);
            cmp("row_from", e.row_from, rsp_row_from);
            cmp("row_to", e.row_to, rsp_row_to);
            cmp("pal_dirty", e.pal_dirty, rsp_pal_dirty);
            cmp("pal_from", e.pal_from, rsp_pal_from);
            cmp("pal_to", e.pal_to, rsp_pal_to);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("fli_flc_frame_decoder regression: fail");
         $finish;
      end
   end

   task wait_idle();
      do @(posedge clock);
      while (byte_q.size() != 0 || cmd_q.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back
   task csr_write(logic [2:0] addr, int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_WIDTH) width_reg = value & 11'h7FF;
      else height_reg = value & 11'h7FF;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cmp("register read", value & 11'h7FF, csr_prdata[10:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task run_setting(int unsigned w, int unsigned h, int nbytes);
      int start;
      wait_idle();
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
      start = bytes_taken;
      while (bytes_taken + byte_q.size() - start < nbytes) begin
         gen_frame();
         do @(posedge clock);
         while (byte_q.size() > 40);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset sizes
      exact_sizes = 1;
      frame_body.push_back(8'h00);
      frame_body.push_back(8'hFF);
      close_frame(FT_PREFIX, 0, 18);
      close_frame(FT_FILLER, 0, 16);
      close_frame(FT_FRAME, 0, 4);
      close_frame(FT_FRAME, 1, 16);
      gen_chunk(4);
      gen_chunk(0);
      gen_chunk(7);
      close_frame(FT_FRAME, 3, frame_body.size() + 16);
      gen_chunk(2);
      gen_chunk(3);
      gen_chunk(1);
      close_frame(FT_FRAME, 3, frame_body.size() + 16);
      exact_sizes = 0;

      run_setting(1, 1, 190);
      run_setting(1024, 1024, 190);
      run_setting($urandom_range(2, 20), $urandom_range(1, 6), 190);
      run_setting($urandom_range(1, 64), $urandom_range(1, 8), 190);
      run_setting(1024, 1, 190);

      // bad magic last: the block then ignores everything
      wait_idle();
      close_frame(16'h1234, 1, 40);
      for (int i = 0; i < 6; i++) byte_q.push_back(8'($urandom_range(0, 255)));
      wait_idle();

      if (errors == 0) begin
         $display("fli_flc_frame_decoder regression: pass");
      end else begin
         $display("fli_flc_frame_decoder regression: fail");
      end
      $finish;
   end

endmodule
